### rtl/lsfd_pkg.sv
`default_nettype none

package lsfd_pkg;

    // Field widths of one input and one output beat
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 16;
    localparam int IDX_W     = 8;
    localparam int DIST_W    = 21;
    localparam int ANGLE_W   = 20;
    localparam int POS_W     = 10;

    // Angle word: (w >> 1) / 64 is the integer angle in degrees, 9 bits wide
    localparam int ANG_SHIFT  = 7;
    localparam int ANG_BASE_W = WORD_W - ANG_SHIFT;

    // Distance raw count is in quarter millimeters
    localparam int DIST_SHIFT = 2;

    // Sync header bytes
    localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'hAA;
    localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h55;

    // Byte positions inside the packet header
    localparam logic [POS_W-1:0] POS_HDR_FIRST  = 10'd0;
    localparam logic [POS_W-1:0] POS_HDR_SECOND = 10'd1;
    localparam logic [POS_W-1:0] POS_TYPE       = 10'd2;
    localparam logic [POS_W-1:0] POS_COUNT      = 10'd3;
    localparam logic [POS_W-1:0] POS_START_LO   = 10'd4;
    localparam logic [POS_W-1:0] POS_START_HI   = 10'd5;
    localparam logic [POS_W-1:0] POS_END_LO     = 10'd6;
    localparam logic [POS_W-1:0] POS_END_HI     = 10'd7;
    localparam logic [POS_W-1:0] POS_CHK_LO     = 10'd8;
    localparam logic [POS_W-1:0] POS_CHK_HI     = 10'd9;
    localparam logic [POS_W-1:0] POS_DATA       = 10'd10;

    // Packet type bit that flags the start of a lap
    localparam int LAP_BIT = 0;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // input beat taken this cycle
        logic mul;        // register distance and index*span products
        logic div_start;  // launch the interpolation divide
        logic fin;        // form final angle and clamped distance
        logic load;       // move staged result into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic sample_end; // current byte completes a sample
        logic empty_end;  // current byte closes a packet with no samples
        logic div_done;   // divider finished
        logic out_free;   // output register can take a result
    } t_stat;

endpackage

`default_nettype wire

### rtl/lsfd_div.sv
`default_nettype none

// Restoring unsigned divide, one quotient bit per cycle
module lsfd_div #(
    parameter int W = 27
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [W-1:0]                  i_dividend,
    input  wire logic [lsfd_pkg::IDX_W-1:0]    i_divisor,
    output logic      [W-1:0]                  o_quotient,
    output logic                               o_done
);

    localparam int CW = (W > 1) ? $clog2(W) : 1;
    localparam int DW = lsfd_pkg::IDX_W;

    logic [W-1:0]  r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0]   trial;
    logic          fits;

    // Shift in next dividend bit and test against divisor
    assign trial = {r_rem, r_quo[W-1]};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                if (fits) begin
                    r_rem <= DW'(trial - {1'b0, r_dvs});
                end else begin
                    r_rem <= trial[DW-1:0];
                end
                r_quo <= {r_quo[W-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

`default_nettype wire

### rtl/lsfd_ctrl.sv
`default_nettype none

module lsfd_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire lsfd_pkg::t_stat i_stat,
    output lsfd_pkg::t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DSTART,
        S_DIV,
        S_FIN,
        S_HOLD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    // Command decode
    always_comb begin
        o_cmd           = '0;
        o_cmd.accept    = accept;
        o_cmd.mul       = (r_state == S_MUL);
        o_cmd.div_start = (r_state == S_DSTART);
        o_cmd.fin       = (r_state == S_FIN);
        o_cmd.load      = (r_state == S_HOLD) && i_stat.out_free;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_stat.sample_end) begin
                    n_state = S_MUL;
                end else if (accept && i_stat.empty_end) begin
                    n_state = S_HOLD;
                end
            end
            S_MUL:    n_state = S_DSTART;
            S_DSTART: n_state = S_DIV;
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN:    n_state = S_HOLD;
            S_HOLD: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### rtl/lsfd_dp.sv
`default_nettype none

module lsfd_dp #(
    parameter int RESOLUTION = 1000
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire lsfd_pkg::t_cmd                    i_cmd,
    output lsfd_pkg::t_stat                        o_stat,
    input  wire logic [lsfd_pkg::BYTE_W-1:0]       i_rx_byte,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic                                   o_has_sample,
    output logic      [lsfd_pkg::IDX_W-1:0]        o_sample_index,
    output logic      [lsfd_pkg::DIST_W-1:0]       o_distance,
    output logic      [lsfd_pkg::ANGLE_W-1:0]      o_angle,
    output logic                                   o_last_sample,
    output logic                                   o_frame_ok,
    output logic                                   o_lap_start
);

    localparam int BW    = lsfd_pkg::BYTE_W;
    localparam int WW    = lsfd_pkg::WORD_W;
    localparam int IW    = lsfd_pkg::IDX_W;
    localparam int PW    = lsfd_pkg::POS_W;
    localparam int RES_W = $clog2(RESOLUTION + 1);
    // Unsigned angle base, signed span, signed product, product magnitude, angle sum, distance product
    localparam int AW    = lsfd_pkg::ANG_BASE_W + RES_W;
    localparam int SW    = AW + 1;
    localparam int PRW   = SW + IW + 1;
    localparam int MW    = AW + IW;
    localparam int SUMW  = AW + 2;
    localparam int DPW   = WW + RES_W;

    localparam logic [RES_W-1:0] RES_V     = RES_W'(RESOLUTION);
    localparam logic [SW-1:0]    FULL_TURN = SW'(360 * RESOLUTION);
    localparam logic [DPW-1:0]   DIST_MAX  = DPW'(2000 * RESOLUTION);

    // Packet fields and running state
    logic [PW-1:0]  r_pos;
    logic [BW-1:0]  r_type;
    logic [BW-1:0]  r_count;
    logic [WW-1:0]  r_start_word;
    logic [WW-1:0]  r_end_word;
    logic [WW-1:0]  r_exp_chk;
    logic [WW-1:0]  r_run_chk;
    logic [BW-1:0]  r_pending;
    logic [IW-1:0]  r_counter;

    // Angle endpoints and span, refreshed every cycle from the header words
    logic [AW-1:0]         r_a_first;
    logic [AW-1:0]         r_a_last;
    logic signed [SW-1:0]  r_span;

    // Staged result
    logic [WW-1:0]         r_sample;
    logic                  r_has;
    logic [IW-1:0]         r_idx;
    logic                  r_last;
    logic signed [PRW-1:0] r_prod;
    logic [DPW-1:0]        r_dist_full;
    logic [lsfd_pkg::DIST_W-1:0]  r_dist;
    logic [lsfd_pkg::ANGLE_W-1:0] r_ang;

    // Output register
    logic                                r_o_valid;
    logic                                r_o_has;
    logic [IW-1:0]                       r_o_idx;
    logic [lsfd_pkg::DIST_W-1:0]         r_o_dist;
    logic [lsfd_pkg::ANGLE_W-1:0]        r_o_ang;
    logic                                r_o_last;
    logic                                r_o_ok;
    logic                                r_o_lap;

    logic                  b_is_hi;
    logic                  pos_data;
    logic [IW:0]           idx_next;
    logic                  is_last;
    logic [MW-1:0]         prod_mag;
    logic [MW-1:0]         quotient;
    logic                  div_done;
    logic signed [SUMW-1:0] q_signed;
    logic signed [SUMW-1:0] ang_sum;
    logic signed [SUMW-1:0] ang_wrap;
    logic signed [SW-1:0]  span_raw;
    logic [DPW-1:0]        dist_shift;
    logic                  verdict;

    assign pos_data = (r_pos >= lsfd_pkg::POS_DATA);
    assign b_is_hi  = r_pos[0];
    assign idx_next = {1'b0, r_counter} + 1'b1;
    assign is_last  = (idx_next >= {1'b0, r_count});
    assign verdict  = (r_run_chk == r_exp_chk) && !r_type[lsfd_pkg::LAP_BIT];

    // Status to controller
    always_comb begin
        o_stat            = '0;
        o_stat.sample_end = pos_data && b_is_hi;
        o_stat.empty_end  = (r_pos == lsfd_pkg::POS_CHK_HI) && (r_count == '0);
        o_stat.div_done   = div_done;
        o_stat.out_free   = !r_o_valid || i_ready;
    end

    // Byte parser: header hunt, header fields, checksum fold, sample capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_type       <= '0;
            r_count      <= '0;
            r_start_word <= '0;
            r_end_word   <= '0;
            r_exp_chk    <= '0;
            r_run_chk    <= '0;
            r_pending    <= '0;
            r_counter    <= '0;
        end else if (i_cmd.accept) begin
            if (r_pos == lsfd_pkg::POS_HDR_FIRST) begin
                if (i_rx_byte == lsfd_pkg::HDR_FIRST) begin
                    r_run_chk <= {{(WW-BW){1'b0}}, i_rx_byte};
                    r_pos     <= lsfd_pkg::POS_HDR_SECOND;
                end
            end else if (r_pos == lsfd_pkg::POS_HDR_SECOND) begin
                if (i_rx_byte == lsfd_pkg::HDR_SECOND) begin
                    r_run_chk <= r_run_chk ^ {i_rx_byte, {BW{1'b0}}};
                    r_pos     <= lsfd_pkg::POS_TYPE;
                end else if (i_rx_byte == lsfd_pkg::HDR_FIRST) begin
                    r_run_chk <= {{(WW-BW){1'b0}}, i_rx_byte};
                end else begin
                    r_pos <= lsfd_pkg::POS_HDR_FIRST;
                end
            end else if (!pos_data) begin
                // Header words; the checksum word itself is not folded
                if (r_pos != lsfd_pkg::POS_CHK_LO && r_pos != lsfd_pkg::POS_CHK_HI) begin
                    if (b_is_hi) begin
                        r_run_chk <= r_run_chk ^ {i_rx_byte, {BW{1'b0}}};
                    end else begin
                        r_run_chk <= r_run_chk ^ {{(WW-BW){1'b0}}, i_rx_byte};
                    end
                end
                if (r_pos == lsfd_pkg::POS_TYPE) begin
                    r_type <= i_rx_byte;
                end
                if (r_pos == lsfd_pkg::POS_COUNT) begin
                    r_count <= i_rx_byte;
                end
                if (r_pos == lsfd_pkg::POS_START_LO) begin
                    r_start_word <= {{(WW-BW){1'b0}}, i_rx_byte};
                end
                if (r_pos == lsfd_pkg::POS_START_HI) begin
                    r_start_word[WW-1:BW] <= i_rx_byte;
                end
                if (r_pos == lsfd_pkg::POS_END_LO) begin
                    r_end_word <= {{(WW-BW){1'b0}}, i_rx_byte};
                end
                if (r_pos == lsfd_pkg::POS_END_HI) begin
                    r_end_word[WW-1:BW] <= i_rx_byte;
                end
                if (r_pos == lsfd_pkg::POS_CHK_LO) begin
                    r_exp_chk <= {{(WW-BW){1'b0}}, i_rx_byte};
                end
                if (r_pos == lsfd_pkg::POS_CHK_HI) begin
                    r_exp_chk[WW-1:BW] <= i_rx_byte;
                    r_counter          <= '0;
                end
                if (r_pos == lsfd_pkg::POS_CHK_HI && r_count == '0) begin
                    r_pos <= lsfd_pkg::POS_HDR_FIRST;
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
            end else if (!b_is_hi) begin
                r_pending <= i_rx_byte;
                r_run_chk <= r_run_chk ^ {{(WW-BW){1'b0}}, i_rx_byte};
                r_pos     <= r_pos + 1'b1;
            end else begin
                r_run_chk <= r_run_chk ^ {i_rx_byte, {BW{1'b0}}};
                if (is_last) begin
                    r_pos <= lsfd_pkg::POS_HDR_FIRST;
                end else begin
                    r_counter <= idx_next[IW-1:0];
                    r_pos     <= r_pos + 1'b1;
                end
            end
        end
    end

    // Result staging: empty packet, captured sample, or final distance and angle
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && o_stat.empty_end) begin
            r_has  <= 1'b0;
            r_idx  <= '0;
            r_last <= 1'b1;
            r_dist <= '0;
            r_ang  <= '0;
        end else if (i_cmd.accept && o_stat.sample_end) begin
            r_has    <= 1'b1;
            r_idx    <= r_counter;
            r_last   <= is_last;
            r_sample <= {i_rx_byte, r_pending};
        end else if (i_cmd.fin) begin
            r_dist <= lsfd_pkg::DIST_W'((dist_shift > DIST_MAX) ? DIST_MAX : dist_shift);
            r_ang  <= lsfd_pkg::ANGLE_W'($unsigned(ang_wrap));
        end
    end

    // Angle endpoints and span, wrapped once through a full turn
    assign span_raw = $signed({1'b0, r_a_last}) - $signed({1'b0, r_a_first});

    always_ff @(posedge i_clk) begin
        r_a_first <= {{RES_W{1'b0}}, r_start_word[WW-1:lsfd_pkg::ANG_SHIFT]}
                   * {{lsfd_pkg::ANG_BASE_W{1'b0}}, RES_V};
        r_a_last  <= {{RES_W{1'b0}}, r_end_word[WW-1:lsfd_pkg::ANG_SHIFT]}
                   * {{lsfd_pkg::ANG_BASE_W{1'b0}}, RES_V};
        r_span    <= (span_raw < 0) ? SW'(span_raw + $signed(FULL_TURN)) : span_raw;
    end

    // Products: raw distance scale and index times span, full width operands
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_dist_full <= {{RES_W{1'b0}}, r_sample} * {{WW{1'b0}}, RES_V};
            r_prod      <= $signed({{(PRW-IW){1'b0}}, r_idx}) * PRW'(r_span);
        end
    end

    assign prod_mag   = r_prod[PRW-1] ? MW'(-r_prod) : MW'(r_prod);
    assign dist_shift = r_dist_full >> lsfd_pkg::DIST_SHIFT;

    lsfd_div #(
        .W (MW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (prod_mag),
        .i_divisor  (IW'(r_count - 1'b1)),
        .o_quotient (quotient),
        .o_done     (div_done)
    );

    // Interpolated angle, truncated toward zero, wrapped once, floored at zero
    always_comb begin
        q_signed = $signed({1'b0, quotient[AW-1:0]});
        if (r_prod[PRW-1]) begin
            q_signed = -q_signed;
        end
        if (r_count > {{(BW-1){1'b0}}, 1'b1}) begin
            ang_sum = q_signed + $signed({2'b00, r_a_first});
        end else begin
            ang_sum = $signed({2'b00, r_a_first});
        end
        ang_wrap = ang_sum;
        if (ang_sum >= $signed({1'b0, FULL_TURN})) begin
            ang_wrap = ang_sum - $signed({1'b0, FULL_TURN});
        end
        if (ang_wrap < 0) begin
            ang_wrap = '0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_has  <= r_has;
            r_o_idx  <= r_idx;
            r_o_dist <= r_dist;
            r_o_ang  <= r_ang;
            r_o_last <= r_last;
            r_o_ok   <= r_last && verdict;
            r_o_lap  <= r_type[lsfd_pkg::LAP_BIT];
        end
    end

    assign o_valid        = r_o_valid;
    assign o_has_sample   = r_o_has;
    assign o_sample_index = r_o_idx;
    assign o_distance     = r_o_dist;
    assign o_angle        = r_o_ang;
    assign o_last_sample  = r_o_last;
    assign o_frame_ok     = r_o_ok;
    assign o_lap_start    = r_o_lap;

endmodule

`default_nettype wire

### rtl/lidar_scan_frame_decoder.sv
// Header and low sample bytes: taken whenever o_ready is high; only the
// last header byte of an empty packet gives a result beat. Sample high byte:
// result beat after the multiply, divide and final states; the bit-serial
// divider is W = 17 + clog2(RESOLUTION+1) (27 at 1000) bits wide. No new byte
// is taken while a sample is in flight; one result per divide. Reset (i_rst_n
// low, synchronous) clears the parser to header hunt and empties the output register.
`default_nettype none

module lidar_scan_frame_decoder #(
    parameter int RESOLUTION = 1000
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [lsfd_pkg::BYTE_W-1:0]       i_rx_byte,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic                                   o_has_sample,
    output logic      [lsfd_pkg::IDX_W-1:0]        o_sample_index,
    output logic      [lsfd_pkg::DIST_W-1:0]       o_distance,
    output logic      [lsfd_pkg::ANGLE_W-1:0]      o_angle,
    output logic                                   o_last_sample,
    output logic                                   o_frame_ok,
    output logic                                   o_lap_start
);

    lsfd_pkg::t_cmd  cmd;
    lsfd_pkg::t_stat stat;

    lsfd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    lsfd_dp #(
        .RESOLUTION (RESOLUTION)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_has_sample   (o_has_sample),
        .o_sample_index (o_sample_index),
        .o_distance     (o_distance),
        .o_angle        (o_angle),
        .o_last_sample  (o_last_sample),
        .o_frame_ok     (o_frame_ok),
        .o_lap_start    (o_lap_start)
    );

endmodule

`default_nettype wire
